@@ src/midi_clock_tempo_tracker_core_defines.svh @@
// Assertion macros shared by the tempo tracker checker.
`ifndef MIDI_CLOCK_TEMPO_TRACKER_CORE_DEFINES_SVH
`define MIDI_CLOCK_TEMPO_TRACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mctt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mctt: next-cycle check failed");

`endif

@@ src/mctt_pkg.sv @@
// Types and constants shared by the MIDI clock tempo tracker modules.
package mctt_pkg;

	// Field widths.
	localparam int TEMPO_W   = 26;
	localparam int ITEMPO_W  = 25;
	localparam int BEAT_W    = 48;
	localparam int FUNC_W    = 3;
	localparam int SRC_W     = 2;
	localparam int IV_W      = 24;
	localparam int DT_W      = 20;
	localparam int SIL_W     = 22;
	localparam int TCNT_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 25;

	// Serial divider geometry: a 48-bit dividend, 32 quotient bits, one per cycle.
	localparam int DIV_W     = 48;
	localparam int DIV_Q_W   = 32;
	localparam int DIVSR_W   = 24;
	localparam int DIV_STEPS = DIV_Q_W;

	// Product of clamped internal tempo and block duration.
	localparam int NUM_W = ITEMPO_W + DT_W;

	// Operation codes of an input item.
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_BLOCK = 3'd4;

	// Clock source codes.
	localparam logic [SRC_W-1:0] SRC_INT  = 2'd0;
	localparam logic [SRC_W-1:0] SRC_HOST = 2'd1;
	localparam logic [SRC_W-1:0] SRC_MIDI = 2'd2;
	localparam logic [SRC_W-1:0] SRC_ALT  = 2'd3;

	// Configuration register indices.
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SOURCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_TEMPO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_RUN   = 2'd2;

	// Tempo constants in Q10.16 bpm.
	localparam logic [TEMPO_W-1:0]  ONE_BPM      = 26'd65536;
	localparam logic [TEMPO_W-1:0]  TEMPO_SAT    = 26'h3FFFFFF;
	localparam logic [ITEMPO_W-1:0] TEMPO_MIN    = 25'd1310720;
	localparam logic [ITEMPO_W-1:0] TEMPO_MAX    = 25'd19660800;
	localparam logic [ITEMPO_W-1:0] TEMPO_RESET  = 25'd7864320;
	localparam logic [12:0]         SMOOTH_K     = 13'd5243;
	localparam int                  SMOOTH_SHIFT = 16;

	// Tick intervals and silence, in microseconds.
	localparam logic [IV_W-1:0]  IV_LOW      = 24'd2000;
	localparam logic [IV_W-1:0]  IV_HIGH     = 24'd2000000;
	localparam logic [SIL_W-1:0] SILENCE_MAX = 22'd2000000;

	// 60 s / 24 ticks in microseconds, scaled by 2^16.
	localparam logic [DIV_W-1:0] TICK_NUM = 48'd163840000000;

	// Odd factor of the beat denominator 327680000000 = 2^22 * 78125.
	localparam logic [DIVSR_W-1:0] BEAT_DIVSR  = 24'd78125;
	localparam int                 BEAT_DEN_P2 = 22;

	localparam int TICKS_PER_BEAT = 24;

	typedef logic [TEMPO_W-1:0] tempo_t;
	typedef logic [BEAT_W-1:0]  beat_t;

	// Request to the serial divider.
	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVSR_W-1:0]   divisor;
	} div_req_t;

	// Status and result of the serial divider.
	typedef struct packed {
		logic                 done;
		logic [DIV_Q_W-1:0]   quotient;
	} div_stat_t;

endpackage

@@ src/mctt_serial_div.sv @@
// Bit-serial restoring divider: one quotient bit per clock.
module mctt_serial_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mctt_pkg::div_req_t  req,
	output mctt_pkg::div_stat_t stat
);
	import mctt_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [DIVSR_W-1:0] rem_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIVSR_W-1:0] dsr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIVSR_W:0]   trial;
	logic               fits;
	logic [DIVSR_W-1:0] rem_next;

	// One restoring step: bring in the next dividend bit and try a subtraction.
	always_comb begin
		trial    = {rem_q, quo_q[DIV_Q_W-1]};
		fits     = trial >= {1'b0, dsr_q};
		rem_next = fits ? DIVSR_W'(trial - {1'b0, dsr_q}) : trial[DIVSR_W-1:0];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient register shifts dividend bits out and quotient bits in.
	// The upper dividend bits are below the divisor, so they preload the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIVSR_W'(req.dividend[DIV_W-1:DIV_Q_W]);
			quo_q <= req.dividend[DIV_Q_W-1:0];
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_Q_W-2:0], fits};
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule

@@ src/mctt_smooth.sv @@
// Tempo smoothing: moves the old tempo towards the new one by 5243/65536 of the gap.
module mctt_smooth (
	input  logic             clk,
	input  logic             load,
	input  mctt_pkg::tempo_t tempo_new,
	input  mctt_pkg::tempo_t tempo_old,
	output mctt_pkg::tempo_t tempo_out
);
	import mctt_pkg::*;

	localparam int PROD_W = TEMPO_W + $bits(SMOOTH_K);
	localparam int ADJ_W  = PROD_W - SMOOTH_SHIFT;

	logic              neg;
	logic [TEMPO_W-1:0] gap;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [ADJ_W-1:0]  adj;

	// Magnitude of the gap; the shift truncates towards zero on either side.
	always_comb begin
		neg = tempo_new < tempo_old;
		gap = neg ? (tempo_old - tempo_new) : (tempo_new - tempo_old);
	end

	// Registered product of the gap and the smoothing factor.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_W'(gap) * PROD_W'(SMOOTH_K);
			neg_q  <= neg;
		end
	end

	// Apply the adjustment with the sign of the gap.
	always_comb begin
		adj       = prod_q[PROD_W-1:SMOOTH_SHIFT];
		tempo_out = neg_q ? (tempo_old - TEMPO_W'(adj)) : (tempo_old + TEMPO_W'(adj));
	end

endmodule

@@ src/midi_clock_tempo_tracker_core.sv @@
// Top level of the MIDI clock tempo tracker: sequencer, tracker state and output register.
//
// One item is processed at a time; each accepted item yields exactly one result holding
// the tempo, beat, running flag and source latched at the most recent block step.
// Start, continue, stop, unused codes, out-of-range ticks and block steps that do not
// advance the internal beat counter go from the execute state to the done state. A MIDI
// tick whose interval lies strictly between 2 ms and 2 s, and a block step that advances
// the running internal beat counter, pass through the shared bit-serial divider, which
// produces one quotient bit per cycle. Such a tick then goes to the done state, through
// the smoothing state when its tempo is smoothed; a beat advance passes the multiply
// state first. The done state presents the result once the output is free. The block
// is ready for the next item as soon as a result is presented, so a new item is taken
// while the previous result still waits on the output.
module midi_clock_tempo_tracker_core #(
	parameter int BEAT_FRAC_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [mctt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mctt_pkg::CFG_DAT_W-1:0]       cfg_data,
	// Input items.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mctt_pkg::FUNC_W-1:0]          func,
	input  logic [mctt_pkg::IV_W-1:0]            interval_us,
	input  logic [mctt_pkg::DT_W-1:0]            dt_us,
	input  logic                                 host_valid,
	input  mctt_pkg::tempo_t                     host_bpm,
	input  mctt_pkg::beat_t                      host_beat,
	input  logic                                 host_playing,
	// Result items.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output mctt_pkg::tempo_t                     bpm,
	output mctt_pkg::beat_t                      beat,
	output logic                                 running,
	output logic [mctt_pkg::SRC_W-1:0]           source_used
);
	import mctt_pkg::*;

	// Alignment of the tempo-times-duration product to the odd beat divisor.
	localparam int BEAT_LSH = (BEAT_FRAC_BITS + 1 >= BEAT_DEN_P2) ?
		BEAT_FRAC_BITS + 1 - BEAT_DEN_P2 : 0;
	localparam int BEAT_RSH = (BEAT_FRAC_BITS + 1 < BEAT_DEN_P2) ?
		BEAT_DEN_P2 - BEAT_FRAC_BITS - 1 : 0;
	localparam beat_t TICK_STEP = beat_t'(1) << BEAT_FRAC_BITS;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EXEC     = 3'd1;
	localparam logic [2:0] ST_MUL      = 3'd2;
	localparam logic [2:0] ST_DIV_TICK = 3'd3;
	localparam logic [2:0] ST_DIV_BEAT = 3'd4;
	localparam logic [2:0] ST_SMOOTH   = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0] state_q;

	// Configuration registers.
	logic [SRC_W-1:0]    clock_source_q;
	logic [ITEMPO_W-1:0] internal_tempo_q;
	logic                internal_run_q;

	// Captured input item.
	logic [FUNC_W-1:0] func_q;
	logic [IV_W-1:0]   iv_q;
	logic [DT_W-1:0]   dt_q;
	logic              host_valid_q;
	tempo_t            host_bpm_q;
	beat_t             host_beat_q;
	logic              host_playing_q;

	// Tracker state.
	tempo_t            midi_tempo_q;
	logic [TCNT_W-1:0] tick_count_q;
	beat_t             midi_beat_q;
	logic              midi_run_q;
	logic [SIL_W-1:0]  silence_q;
	beat_t             int_beat_q;
	tempo_t            tempo_lat_q;
	beat_t             beat_lat_q;
	logic              running_lat_q;
	logic [SRC_W-1:0]  source_lat_q;
	logic              direct_q;
	logic [NUM_W-1:0]  num_q;

	// Output register.
	logic              out_valid_q;
	tempo_t            bpm_q;
	beat_t             beat_q;
	logic              running_q;
	logic [SRC_W-1:0]  source_q;

	// Combinational helpers.
	logic [SRC_W-1:0]    src_eff;
	logic [ITEMPO_W-1:0] tempo_cl;
	logic [SIL_W:0]      sil_sum;
	logic [SIL_W-1:0]    sil_new;
	logic                use_host;
	logic                use_midi;
	logic                iv_ok;
	logic                tick_seen;
	tempo_t              tick_tempo;
	beat_t               int_beat_new;
	logic                out_free;
	tempo_t              smooth_out;
	div_req_t            div_req;
	div_stat_t           div_stat;

	// Shared bit-serial divider for tick tempo and internal beat advance.
	mctt_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// Smoothing of the MIDI tempo once the tick count has filled.
	mctt_smooth u_smooth (
		.clk       (clk),
		.load      (div_stat.done),
		.tempo_new (tick_tempo),
		.tempo_old (midi_tempo_q),
		.tempo_out (smooth_out)
	);

	// Source choice, clamping, silence and tick qualification.
	always_comb begin
		src_eff   = (clock_source_q == SRC_ALT) ? SRC_MIDI : clock_source_q;
		tempo_cl  = internal_tempo_q;
		if (tempo_cl < TEMPO_MIN) begin
			tempo_cl = TEMPO_MIN;
		end
		if (tempo_cl > TEMPO_MAX) begin
			tempo_cl = TEMPO_MAX;
		end
		sil_sum   = (SIL_W + 1)'(silence_q) + (SIL_W + 1)'(dt_q);
		sil_new   = (sil_sum > (SIL_W + 1)'(SILENCE_MAX)) ? SILENCE_MAX : sil_sum[SIL_W-1:0];
		tick_seen = tick_count_q >= TCNT_W'(TICKS_PER_BEAT);
		use_host  = (src_eff == SRC_HOST) && host_valid_q && (host_bpm_q > ONE_BPM);
		use_midi  = (src_eff == SRC_MIDI) && tick_seen && (midi_tempo_q > ONE_BPM) &&
			(sil_new < SILENCE_MAX);
		iv_ok     = (iv_q > IV_LOW) && (iv_q < IV_HIGH);
		tick_tempo = (div_stat.quotient > DIV_Q_W'(TEMPO_SAT)) ? TEMPO_SAT :
			div_stat.quotient[TEMPO_W-1:0];
		int_beat_new = int_beat_q + BEAT_W'(div_stat.quotient);
		out_free  = !out_valid_q || out_ready;
	end

	// Divider requests: tick tempo from the interval, or beat advance from the product.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = TICK_NUM + DIV_W'(iv_q >> 1);
		div_req.divisor  = iv_q;
		if (state_q == ST_EXEC && func_q == FUNC_TICK && iv_ok) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_MUL) begin
			div_req.start    = 1'b1;
			div_req.dividend = (DIV_W'(num_q) << BEAT_LSH) >> BEAT_RSH;
			div_req.divisor  = BEAT_DIVSR;
		end
	end

	// Capture of the accepted item.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q         <= func;
			iv_q           <= interval_us;
			dt_q           <= dt_us;
			host_valid_q   <= host_valid;
			host_bpm_q     <= host_bpm;
			host_beat_q    <= host_beat;
			host_playing_q <= host_playing;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_source_q   <= SRC_INT;
			internal_tempo_q <= TEMPO_RESET;
			internal_run_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOCK_SOURCE:   clock_source_q   <= cfg_data[SRC_W-1:0];
				REG_INTERNAL_TEMPO: internal_tempo_q <= cfg_data[ITEMPO_W-1:0];
				REG_INTERNAL_RUN:   internal_run_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			midi_tempo_q  <= '0;
			tick_count_q  <= '0;
			midi_beat_q   <= '0;
			midi_run_q    <= 1'b0;
			silence_q     <= '0;
			int_beat_q    <= '0;
			tempo_lat_q   <= '0;
			beat_lat_q    <= '0;
			running_lat_q <= 1'b0;
			source_lat_q  <= SRC_INT;
			direct_q      <= 1'b0;
			num_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (func_q)
						FUNC_TICK: begin
							// Direct take is decided on the count before this tick.
							direct_q  <= !tick_seen || (midi_tempo_q <= ONE_BPM);
							silence_q <= '0;
							if (midi_run_q) begin
								midi_beat_q <= midi_beat_q + TICK_STEP;
							end
							if (!tick_seen) begin
								tick_count_q <= tick_count_q + TCNT_W'(1);
							end
							if (iv_ok) begin
								state_q <= ST_DIV_TICK;
							end
						end
						FUNC_START: begin
							midi_beat_q <= '0;
							midi_run_q  <= 1'b1;
						end
						FUNC_CONT: begin
							midi_run_q <= 1'b1;
						end
						FUNC_STOP: begin
							midi_run_q <= 1'b0;
						end
						FUNC_BLOCK: begin
							silence_q <= sil_new;
							if (use_host) begin
								tempo_lat_q   <= host_bpm_q;
								beat_lat_q    <= host_beat_q;
								running_lat_q <= host_playing_q;
								source_lat_q  <= SRC_HOST;
							end else if (use_midi) begin
								tempo_lat_q   <= midi_tempo_q;
								beat_lat_q    <= midi_beat_q;
								running_lat_q <= midi_run_q;
								source_lat_q  <= SRC_MIDI;
							end else begin
								tempo_lat_q   <= TEMPO_W'(tempo_cl);
								running_lat_q <= internal_run_q;
								source_lat_q  <= SRC_INT;
								beat_lat_q    <= int_beat_q;
								if (internal_run_q) begin
									num_q   <= NUM_W'(tempo_cl) * NUM_W'(dt_q);
									state_q <= ST_MUL;
								end
							end
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					state_q <= ST_DIV_BEAT;
				end
				ST_DIV_TICK: begin
					if (div_stat.done) begin
						if (direct_q) begin
							midi_tempo_q <= tick_tempo;
							state_q      <= ST_DONE;
						end else begin
							state_q <= ST_SMOOTH;
						end
					end
				end
				ST_DIV_BEAT: begin
					if (div_stat.done) begin
						int_beat_q <= int_beat_new;
						beat_lat_q <= int_beat_new;
						state_q    <= ST_DONE;
					end
				end
				ST_SMOOTH: begin
					midi_tempo_q <= smooth_out;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded with the latched values when an item completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			bpm_q     <= tempo_lat_q;
			beat_q    <= beat_lat_q;
			running_q <= running_lat_q;
			source_q  <= source_lat_q;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign bpm         = bpm_q;
	assign beat        = beat_q;
	assign running     = running_q;
	assign source_used = source_q;

endmodule

@@ src/mctt_port_checker.sv @@
// Port-level checks of the tempo tracker, bound to its top level.
`include "midi_clock_tempo_tracker_core_defines.svh"

module mctt_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input mctt_pkg::tempo_t           bpm,
	input mctt_pkg::beat_t            beat,
	input logic                       running,
	input logic [mctt_pkg::SRC_W-1:0] source_used
);
	import mctt_pkg::*;

	logic                                     out_wait;
	logic [TEMPO_W+BEAT_W+SRC_W:0]            out_word;
	logic                                     ext_src;
	logic                                     int_shown;
	logic                                     int_in_range;

	// Views of the result port used by the checks below.
	assign out_wait     = out_valid && !out_ready;
	assign out_word     = {bpm, beat, running, source_used};
	assign ext_src      = (source_used == SRC_HOST) || (source_used == SRC_MIDI);
	assign int_shown    = out_valid && (source_used == SRC_INT) && (bpm != '0);
	assign int_in_range = (bpm >= TEMPO_W'(TEMPO_MIN)) && (bpm <= TEMPO_W'(TEMPO_MAX));

	// A waiting result holds its value until it is taken.
	`MCTT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, out_valid && $stable(out_word))

	// The block works on one item at a time.
	`MCTT_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

	// Host or MIDI timing is only chosen with a tempo above one bpm.
	`MCTT_ASSERT_IMP(a_ext_tempo, clk, arst_n, out_valid && ext_src, bpm > ONE_BPM)

	// Once latched, the internal tempo lies within its clamp range.
	`MCTT_ASSERT_IMP(a_int_tempo, clk, arst_n, int_shown, int_in_range)

endmodule

bind midi_clock_tempo_tracker_core mctt_port_checker u_port_checker (.*);
